FILE: src/fheat_pkg.sv
// fheat_pkg: grid geometry, field widths, operation codes and the fire palette
// shared by the heat grid modules; depends on nothing
`timescale 1ns / 1ps

package fheat_pkg;

  localparam int GRID_WIDTH   = 160;
  localparam int GRID_HEIGHT  = 120;
  localparam int PIXEL_SCALE  = 4;
  localparam int PALETTE_SIZE = 37;
  localparam int PALETTE_ROWS = 37;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int OP_W   = 2;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int RND_W  = 2;
  localparam int HEAT_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [HEAT_W-1:0] SEED_HEAT = HEAT_W'(PALETTE_SIZE - 1);

  typedef enum logic [OP_W-1:0] {
    OP_SEED   = 2'd0,
    OP_SPREAD = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } color_t;

  function automatic color_t fire_color(input logic [HEAT_W-1:0] heat);
    color_t c;
    case (heat)
      6'd0:    c = '{8'h07, 8'h07, 8'h07};
      6'd1:    c = '{8'h07, 8'h07, 8'h1F};
      6'd2:    c = '{8'h07, 8'h0F, 8'h2F};
      6'd3:    c = '{8'h07, 8'h0F, 8'h47};
      6'd4:    c = '{8'h07, 8'h17, 8'h57};
      6'd5:    c = '{8'h07, 8'h1F, 8'h67};
      6'd6:    c = '{8'h07, 8'h1F, 8'h77};
      6'd7:    c = '{8'h07, 8'h27, 8'h8F};
      6'd8:    c = '{8'h07, 8'h2F, 8'h9F};
      6'd9:    c = '{8'h07, 8'h3F, 8'hAF};
      6'd10:   c = '{8'h07, 8'h47, 8'hBF};
      6'd11:   c = '{8'h07, 8'h47, 8'hC7};
      6'd12:   c = '{8'h07, 8'h4F, 8'hDF};
      6'd13:   c = '{8'h07, 8'h57, 8'hDF};
      6'd14:   c = '{8'h07, 8'h57, 8'hDF};
      6'd15:   c = '{8'h07, 8'h5F, 8'hD7};
      6'd16:   c = '{8'h07, 8'h5F, 8'hD7};
      6'd17:   c = '{8'h0F, 8'h67, 8'hD7};
      6'd18:   c = '{8'h0F, 8'h6F, 8'hCF};
      6'd19:   c = '{8'h0F, 8'h77, 8'hCF};
      6'd20:   c = '{8'h0F, 8'h7F, 8'hCF};
      6'd21:   c = '{8'h17, 8'h87, 8'hCF};
      6'd22:   c = '{8'h17, 8'h87, 8'hC7};
      6'd23:   c = '{8'h17, 8'h8F, 8'hC7};
      6'd24:   c = '{8'h1F, 8'h97, 8'hC7};
      6'd25:   c = '{8'h1F, 8'h9F, 8'hBF};
      6'd26:   c = '{8'h1F, 8'h9F, 8'hBF};
      6'd27:   c = '{8'h27, 8'hA7, 8'hBF};
      6'd28:   c = '{8'h27, 8'hA7, 8'hBF};
      6'd29:   c = '{8'h2F, 8'hAF, 8'hBF};
      6'd30:   c = '{8'h2F, 8'hAF, 8'hB7};
      6'd31:   c = '{8'h2F, 8'hB7, 8'hB7};
      6'd32:   c = '{8'h37, 8'hB7, 8'hB7};
      6'd33:   c = '{8'h6F, 8'hCF, 8'hCF};
      6'd34:   c = '{8'h9F, 8'hDF, 8'hDF};
      6'd35:   c = '{8'hC7, 8'hEF, 8'hEF};
      // last entry and anything hotter show white
      default: c = '{8'hFF, 8'hFF, 8'hFF};
    endcase
    return c;
  endfunction

endpackage

FILE: src/fheat_ram.sv
// fheat_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module fheat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/fheat_addr.sv
// fheat_addr: shared cell address unit, registered row * width + column
// depends on fheat_pkg
`timescale 1ns / 1ps

module fheat_addr (
  input  logic                       clk,
  input  logic [fheat_pkg::ROW_W-1:0] row_in,
  input  logic [fheat_pkg::COL_W-1:0] col_in,
  output logic [fheat_pkg::ADDR_W-1:0] addr
);

  import fheat_pkg::*;

  logic [ADDR_W-1:0] row_base;

  assign row_base = ADDR_W'(row_in) * ADDR_W'(GRID_WIDTH);

  always_ff @(posedge clk) begin
    addr <= row_base + ADDR_W'(col_in);
  end

endmodule

FILE: src/fire_effect_heat_grid_top.sv
// fire_effect_heat_grid_top: sequencer around the heat grid memory and the shared
// address unit; depends on fheat_pkg, fheat_ram and fheat_addr
`timescale 1ns / 1ps

// Heat grid for a fire effect. One input channel (in_valid/in_ready) carries an
// operation with column, row and random_bits; one output channel
// (out_valid/out_ready) returns one result per item: heat_index, blue, green,
// red, status.
// The block takes one item at a time. in_ready is high only while the sequencer
// is idle. A taken item with a range error or OP_NONE goes straight to S_FIN;
// a seed passes S_SRC and S_WR; a read pixel, or a spread on the top row, passes
// S_SRC, S_RD and S_DATA; a spread passes S_SRC, S_RD, S_DATA and S_WR; all end
// in S_FIN. The steps follow from the single address unit, used for the source
// cell and, for a spread, the destination cell, and from the registered read.
// The result register lets a new item be taken while a result waits; if the
// receiver stalls, the next item holds in its last state until the result
// register frees up.
// Reset clears the sequencer and the output valid; the grid contents are
// undefined until seeded, and no clearing pass is run.

module fire_effect_heat_grid_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fheat_pkg::OP_W-1:0]    operation,
  input  logic [fheat_pkg::COL_W-1:0]   column,
  input  logic [fheat_pkg::ROW_W-1:0]   row,
  input  logic [fheat_pkg::RND_W-1:0]   random_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fheat_pkg::HEAT_W-1:0]  heat_index,
  output logic [fheat_pkg::BYTE_W-1:0]  blue,
  output logic [fheat_pkg::BYTE_W-1:0]  green,
  output logic [fheat_pkg::BYTE_W-1:0]  red,
  output logic                          status
);

  import fheat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_RD,
    S_DATA,
    S_WR,
    S_FIN
  } state_t;

  state_t            state;
  op_t               op;
  logic [COL_W-1:0]  cell_col;
  logic [ROW_W-1:0]  cell_row;
  logic [RND_W-1:0]  rnd;
  logic              err;
  logic [HEAT_W-1:0] heat;
  logic [HEAT_W-1:0] wr_val;

  logic              in_xfer;
  op_t               in_op;
  logic              in_err;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;

  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] addr;

  logic              ram_we;
  logic              ram_re;
  logic [HEAT_W-1:0] ram_rdata;

  logic [COL_W-1:0]  dst_col;
  logic [HEAT_W-1:0] spread_val;
  logic [HEAT_W-1:0] pal_idx;
  color_t            color;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_op    = op_t'(operation);
  assign out_free = !out_valid || out_ready;

  // read pixels address the grid at display coordinates scaled down
  always_comb begin
    in_col = column;
    in_row = row;
    in_err = 1'b0;
    case (in_op)
      OP_SEED, OP_SPREAD: begin
        in_err = (column >= COL_W'(GRID_WIDTH)) || (row >= ROW_W'(GRID_HEIGHT));
      end
      OP_READ: begin
        in_col = COL_W'(column / PIXEL_SCALE);
        in_row = ROW_W'(row / PIXEL_SCALE);
        in_err = (in_col >= COL_W'(GRID_WIDTH)) || (in_row >= ROW_W'(GRID_HEIGHT));
      end
      default: begin
        in_err = 1'b0;
      end
    endcase
  end

  // spread target: one row up, shifted sideways by the random bits when hot
  always_comb begin
    dst_col = cell_col;
    if (ram_rdata != '0) begin
      if (rnd == 2'd0 && cell_col != '0) begin
        dst_col = COL_W'(cell_col - 1'b1);
      end else if (rnd == 2'd3 && cell_col < COL_W'(GRID_WIDTH - 1)) begin
        dst_col = COL_W'(cell_col + 1'b1);
      end
    end
    spread_val = (ram_rdata == '0) ? '0 : HEAT_W'(ram_rdata - HEAT_W'(rnd[0]));
  end

  always_comb begin
    if (state == S_DATA) begin
      au_row = ROW_W'(cell_row - 1'b1);
      au_col = dst_col;
    end else begin
      au_row = cell_row;
      au_col = cell_col;
    end
  end

  assign pal_idx = (heat >= HEAT_W'(PALETTE_ROWS - 1)) ? HEAT_W'(PALETTE_ROWS - 1) : heat;
  assign color   = fire_color(pal_idx);
  assign ram_re  = (state == S_RD);
  assign ram_we  = (state == S_WR);

  fheat_addr u_addr (
    .clk    (clk),
    .row_in (au_row),
    .col_in (au_col),
    .addr   (addr)
  );

  fheat_ram #(
    .WIDTH (HEAT_W),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wr_val),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op       <= in_op;
            cell_col <= in_col;
            cell_row <= in_row;
            rnd      <= random_bits;
            err      <= in_err;
            heat     <= '0;
            wr_val   <= (in_op == OP_SEED && row != ROW_W'(GRID_HEIGHT - 1)) ? '0 : SEED_HEAT;
            if (in_err || in_op == OP_NONE) begin
              state <= S_FIN;
            end else begin
              state <= S_SRC;
            end
          end
        end
        S_SRC: begin
          state <= (op == OP_SEED) ? S_WR : S_RD;
        end
        S_RD: begin
          state <= S_DATA;
        end
        S_DATA: begin
          heat   <= ram_rdata;
          wr_val <= spread_val;
          // the top row has nowhere to spread
          if (op == OP_SPREAD && cell_row != '0) begin
            state <= S_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_WR: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            status     <= err;
            heat_index <= (op == OP_SEED || err) ? '0 : heat;
            if (op == OP_READ && !err) begin
              blue  <= color.blue;
              green <= color.green;
              red   <= color.red;
            end else begin
              blue  <= '0;
              green <= '0;
              red   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_write_on_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> !ram_we)
    else $error("grid write in the cycle an item is taken");

  a_rd_wr_apart: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("grid read and write in the same cycle");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> out_valid)
    else $error("finished item did not reach the result register");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (heat_index == '0 && blue == '0 && green == '0 && red == '0))
    else $error("range error result carries data");

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!err && (op == OP_SEED || op == OP_SPREAD)))
    else $error("grid written for an item that must change nothing");
`endif

endmodule
